// ===== rtl/cmap_segment_reverse_mapper_top_macros.svh =====
// Assertion macros shared by the reverse mapper RTL.
`ifndef CMAP_SEGMENT_REVERSE_MAPPER_TOP_MACROS_SVH
`define CMAP_SEGMENT_REVERSE_MAPPER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/csrm_pkg.sv =====
// Types and constants of the segment reverse mapper.
package csrm_pkg;

    localparam int MAP_ENTRIES = 65536;
    localparam int MAP_AW      = 16;
    localparam int IDX_W       = 19;

    typedef logic [15:0] t_code;
    typedef logic [16:0] t_count;
    typedef logic [1:0]  t_mode;

    localparam t_mode MODE_LOAD   = 2'd0;
    localparam t_mode MODE_SEG    = 2'd1;
    localparam t_mode MODE_LOOKUP = 2'd2;
    localparam t_mode MODE_CLEAR  = 2'd3;

    localparam t_code SKIP_CODE = 16'hFFFF;

    // Input tdata field offsets
    localparam int WI_LSB    = 0;
    localparam int GW_LSB    = 12;
    localparam int SEG_LSB   = 28;
    localparam int START_LSB = 43;
    localparam int END_LSB   = 59;
    localparam int DELTA_LSB = 75;
    localparam int RANGE_LSB = 91;
    localparam int GID_LSB   = 107;
    localparam int IN_DATA_W = 128;
    localparam int OUT_DATA_W = 40;

endpackage

// ===== rtl/csrm_ram.sv =====
// Generic simple dual-port RAM with registered, read-first output.
module csrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cmap_segment_reverse_mapper_top.sv =====
// Top level of the segment reverse mapper: glyph word store, reverse map and sequencer.
//
// Input stream (s_axis): one transaction per command, mode in tuser. Mode 0 loads a
// glyph-index word, mode 1 runs one segment, mode 2 reads one map entry, mode 3 clears
// the map. Every command returns exactly one transaction on m_axis.
// Config: i_cfg_wen writes segment_count from i_cfg_wdata.
// Throughput is bound by the single map write port: a segment issues one code per
// cycle through a three-stage read/modify/write pipeline (glyph store read, map read,
// map write), with a one-entry forward path for back-to-back hits on the same entry.
// A skipped or reversed segment goes straight to its result, bypassing the pipeline.
// Reset: a clearing pass writes zero to all 65536 map entries, one per cycle; the
// input stays not ready until the pass ends. The glyph store is not cleared.
// Stall: a finished result waits in the output register; the block takes the next
// command meanwhile and holds its own result until the register frees up.
module cmap_segment_reverse_mapper_top
    import csrm_pkg::*;
#(
    parameter int GLYPH_WORDS = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [14:0]           i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // word_index[11:0], glyph_word[27:12], segment_number[42:28], start_code[58:43],
    // end_code[74:59], id_delta[90:75], range_offset[106:91], glyph_id[122:107], zeros
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // code_point[15:0], entries_written[32:16], bad_offset[33], zeros
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int GW_AW = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SEG   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_LOOK  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Input fields
    t_mode       in_mode;
    logic [11:0] in_wi;
    t_code       in_gw;
    logic [14:0] in_seg;
    t_code       in_start;
    t_code       in_end;
    t_code       in_delta;
    t_code       in_range;
    t_code       in_gid;

    assign in_mode  = s_axis_tuser;
    assign in_wi    = s_axis_tdata[WI_LSB +: 12];
    assign in_gw    = s_axis_tdata[GW_LSB +: 16];
    assign in_seg   = s_axis_tdata[SEG_LSB +: 15];
    assign in_start = s_axis_tdata[START_LSB +: 16];
    assign in_end   = s_axis_tdata[END_LSB +: 16];
    assign in_delta = s_axis_tdata[DELTA_LSB +: 16];
    assign in_range = s_axis_tdata[RANGE_LSB +: 16];
    assign in_gid   = s_axis_tdata[GID_LSB +: 16];

    logic [2:0]        r_state, n_state;
    logic [14:0]       r_seg_cnt;
    logic [MAP_AW-1:0] r_clr;
    logic              r_clr_rsp;
    t_code             r_j;
    t_code             r_end;
    t_code             r_delta;
    logic              r_direct;
    logic [IDX_W-1:0]  r_idx;
    t_code             r_res_code;
    t_count            r_cnt;
    logic              r_bad;
    logic              r_out_v;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Pipeline stages
    logic        r_s1_v;
    t_code       r_s1_j;
    logic        r_s1_ok;
    logic        r_s2_v;
    t_code       r_s2_g;
    t_code       r_s2_j;
    logic        r_fw_v;
    t_code       r_fw_a;
    t_code       r_fw_d;

    logic        accept;
    logic        seg_skip;
    logic        idx_ok;
    logic        out_free;
    logic [16:0] wi_ext;
    logic        load_ok;
    t_code       gw_rdata;
    t_code       map_rdata;
    logic        s1_need;
    t_code       s1_g;
    logic        fw_hit;
    logic        s2_empty;
    logic        s2_we;
    logic        map_we;
    t_code       map_waddr;
    t_code       map_wdata;
    t_code       map_raddr;
    logic [IDX_W-1:0] idx_base;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_v || m_axis_tready;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;

    assign seg_skip = (in_start == SKIP_CODE) || (in_end == SKIP_CODE) || (in_start > in_end);
    assign idx_ok   = !r_idx[IDX_W-1] && (r_idx[IDX_W-2:0] < (IDX_W-1)'(GLYPH_WORDS));
    assign wi_ext   = {5'd0, in_wi};
    assign load_ok  = (wi_ext < 17'(GLYPH_WORDS));
    assign idx_base = {4'd0, in_range[15:1]} + {4'd0, in_seg} - {4'd0, r_seg_cnt};

    // Stage 1: glyph word arrives, form map address and read it
    assign s1_need = r_direct || (r_s1_ok && (gw_rdata != '0));
    assign s1_g    = (r_direct ? r_s1_j : gw_rdata) + r_delta;

    // Stage 2: map entry arrives, forward the write of the previous code
    assign fw_hit   = r_fw_v && (r_fw_a == r_s2_g);
    assign s2_empty = fw_hit ? (r_fw_d == '0) : (map_rdata == '0);
    assign s2_we    = r_s2_v && (r_direct || s2_empty);

    assign map_we    = (r_state == ST_CLEAR) || s2_we;
    assign map_waddr = (r_state == ST_CLEAR) ? r_clr : r_s2_g;
    assign map_wdata = (r_state == ST_CLEAR) ? '0 : r_s2_j;
    assign map_raddr = (r_state == ST_IDLE) ? in_gid : s1_g;

    csrm_ram #(
        .WIDTH (16),
        .DEPTH (GLYPH_WORDS)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (accept && (in_mode == MODE_LOAD) && load_ok),
        .i_waddr (wi_ext[GW_AW-1:0]),
        .i_wdata (in_gw),
        .i_raddr (r_idx[GW_AW-1:0]),
        .o_rdata (gw_rdata)
    );

    csrm_ram #(
        .WIDTH (16),
        .DEPTH (MAP_ENTRIES)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = r_clr_rsp ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_mode)
                        MODE_LOAD:   n_state = ST_DONE;
                        MODE_SEG:    n_state = seg_skip ? ST_DONE : ST_SEG;
                        MODE_LOOKUP: n_state = ST_LOOK;
                        MODE_CLEAR:  n_state = ST_CLEAR;
                    endcase
                end
            end
            ST_SEG: begin
                if (r_j == r_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_v && !r_s2_v) begin
                    n_state = ST_DONE;
                end
            end
            ST_LOOK: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_seg_cnt <= 15'd1;
            r_clr     <= '0;
            r_clr_rsp <= 1'b0;
            r_out_v   <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_fw_v    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wen) begin
                r_seg_cnt <= i_cfg_wdata;
            end

            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end

            // Issue one code per cycle
            r_s1_v <= (r_state == ST_SEG);
            r_s2_v <= r_s1_v && s1_need;
            r_fw_v <= s2_we;

            if (accept) begin
                r_res_code <= '0;
                r_cnt      <= '0;
                r_bad      <= 1'b0;
                r_j        <= in_start;
                r_end      <= in_end;
                r_delta    <= in_delta;
                r_direct   <= (in_range == '0);
                r_idx      <= idx_base;
                r_clr      <= '0;
                r_clr_rsp  <= 1'b1;
            end

            if (r_state == ST_SEG) begin
                if (!r_direct && !idx_ok) begin
                    r_bad <= 1'b1;
                end
                r_j   <= r_j + 1'b1;
                r_idx <= r_idx + 1'b1;
            end

            if (s2_we) begin
                r_cnt <= r_cnt + 1'b1;
            end

            if (r_state == ST_LOOK) begin
                r_res_code <= map_rdata;
            end

            // Hand the result to the output register once it frees up
            if ((r_state == ST_DONE) && out_free) begin
                r_out_v    <= 1'b1;
                r_out_data <= {6'd0, r_bad, r_cnt, r_res_code};
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload of the pipeline stages
    always_ff @(posedge i_clk) begin
        r_s1_j  <= r_j;
        r_s1_ok <= idx_ok;
        r_s2_g  <= s1_g;
        r_s2_j  <= r_s1_j;
        r_fw_a  <= r_s2_g;
        r_fw_d  <= r_s2_j;
    end

`include "cmap_segment_reverse_mapper_top_macros.svh"

    `CSRM_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, r_state == ST_CLEAR, !s_axis_tready, "command accepted during map clear")
    `CSRM_ASSERT_NOW(a_s2_in_segment, i_clk, i_rst_n, r_s2_v, (r_state == ST_SEG) || (r_state == ST_DRAIN), "map write stage active outside a segment")
    `CSRM_ASSERT_NOW(a_out_from_done, i_clk, i_rst_n, $rose(r_out_v), $past(r_state == ST_DONE), "result appeared without a finished command")
    `CSRM_ASSERT_NEXT(a_drain_leaves_done, i_clk, i_rst_n, (r_state == ST_DRAIN) && !r_s1_v && !r_s2_v, (r_state == ST_DONE) && !r_s2_v, "drain did not complete with empty pipeline")

endmodule

// ===== dv/tb.sv =====
// Testbench for the segment reverse mapper: directed and random commands against a map model.
`timescale 1ns / 1ps

module tb;
    import csrm_pkg::*;

    localparam int STORE_WORDS   = 4096;
    localparam int WORD_WINDOW   = 256;
    localparam int STALL_LIMIT   = 250000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 250;
    localparam int HOT_DEPTH     = 128;

    // Result fields in m_axis_tdata
    localparam int CP_LSB  = 0;
    localparam int EW_LSB  = 16;
    localparam int BAD_BIT = 33;

    typedef struct packed {
        t_mode       mode;
        logic [11:0] word_index;
        t_code       glyph_word;
        logic [14:0] segment_number;
        t_code       start_code;
        t_code       end_code;
        t_code       id_delta;
        t_code       range_offset;
        t_code       glyph_id;
    } t_map_cmd;

    typedef struct packed {
        t_code  code_point;
        t_count entries_written;
        logic   bad_offset;
    } t_map_result;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [14:0]           cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data    = '0;
    logic [1:0]            s_user    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;

    // Map model
    t_code       rev_map [MAP_ENTRIES];
    t_code       glyph_words [STORE_WORDS];
    bit          word_loaded [STORE_WORDS];
    logic [14:0] seg_count;
    t_map_result results_due [$];
    t_code       hot_glyphs [$];

    int          errors       = 0;
    int          quiet_cycles = 0;
    bit          src_gaps     = 1'b1;
    bit          snk_gaps     = 1'b1;
    t_map_result want;

    cmap_segment_reverse_mapper_top #(
        .GLYPH_WORDS(STORE_WORDS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (cfg_wen),
        .i_cfg_wdata  (cfg_wdata),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_ready),
        .s_axis_tdata (s_data),
        .s_axis_tuser (s_user),
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_data)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_ready <= !(snk_gaps && $urandom_range(0, 99) < 31);
    end

    function automatic void note_glyph(t_code g);
        if (hot_glyphs.size() < HOT_DEPTH)
            hot_glyphs.push_back(g);
        else
            hot_glyphs[$urandom_range(0, HOT_DEPTH - 1)] = g;
    endfunction

    // Advance the map model by one command and return the result it produces.
    function automatic t_map_result apply_cmd(t_map_cmd c);
        t_map_result r;
        int unsigned code;
        longint      widx;
        t_code       g;
        r = '0;
        case (c.mode)
            MODE_LOAD: begin
                glyph_words[c.word_index] = c.glyph_word;
                word_loaded[c.word_index] = 1'b1;
            end
            MODE_SEG: begin
                if (c.start_code != SKIP_CODE && c.end_code != SKIP_CODE) begin
                    for (code = c.start_code; code <= c.end_code; code++) begin
                        if (c.range_offset == '0) begin
                            g = t_code'(code + c.id_delta);
                            rev_map[g] = t_code'(code);
                            note_glyph(g);
                            r.entries_written++;
                        end else begin
                            widx = longint'(c.range_offset >> 1) + longint'(code - c.start_code)
                                 + longint'(c.segment_number) - longint'(seg_count);
                            if (widx < 0 || widx >= STORE_WORDS) begin
                                r.bad_offset = 1'b1;
                            end else if (glyph_words[widx] != '0) begin
                                g = glyph_words[widx] + c.id_delta;
                                // first writer wins on the indirect path
                                if (rev_map[g] == '0) begin
                                    rev_map[g] = t_code'(code);
                                    note_glyph(g);
                                    r.entries_written++;
                                end
                            end
                        end
                    end
                end
            end
            MODE_LOOKUP: begin
                r.code_point = rev_map[c.glyph_id];
            end
            default: begin
                foreach (rev_map[i]) rev_map[i] = '0;
            end
        endcase
        return r;
    endfunction

    function automatic t_code random_word();
        return ($urandom_range(0, 9) == 0) ? t_code'(0) : t_code'($urandom);
    endfunction

    // Fill every field at random; each builder then sets what its mode uses.
    function automatic t_map_cmd noise_cmd();
        t_map_cmd c;
        c.mode           = t_mode'($urandom_range(0, 3));
        c.word_index     = 12'($urandom);
        c.glyph_word     = t_code'($urandom);
        c.segment_number = 15'($urandom);
        c.start_code     = t_code'($urandom);
        c.end_code       = t_code'($urandom);
        c.id_delta       = t_code'($urandom);
        c.range_offset   = t_code'($urandom);
        c.glyph_id       = t_code'($urandom);
        return c;
    endfunction

    function automatic t_map_cmd load_cmd(logic [11:0] idx, t_code w);
        t_map_cmd c;
        c            = noise_cmd();
        c.mode       = MODE_LOAD;
        c.word_index = idx;
        c.glyph_word = w;
        return c;
    endfunction

    function automatic t_map_cmd segment_cmd(logic [14:0] seg, t_code first, t_code last,
                                             t_code delta, t_code offset);
        t_map_cmd c;
        c                = noise_cmd();
        c.mode           = MODE_SEG;
        c.segment_number = seg;
        c.start_code     = first;
        c.end_code       = last;
        c.id_delta       = delta;
        c.range_offset   = offset;
        return c;
    endfunction

    function automatic t_map_cmd lookup_cmd(t_code gid);
        t_map_cmd c;
        c          = noise_cmd();
        c.mode     = MODE_LOOKUP;
        c.glyph_id = gid;
        return c;
    endfunction

    function automatic t_map_cmd clear_cmd();
        t_map_cmd c;
        c      = noise_cmd();
        c.mode = MODE_CLEAR;
        return c;
    endfunction

    // Enter and leave on a falling edge; valid stays high for a following transaction.
    task automatic issue_cmd(input t_map_cmd c);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[WI_LSB +: 12]    = c.word_index;
        d[GW_LSB +: 16]    = c.glyph_word;
        d[SEG_LSB +: 15]   = c.segment_number;
        d[START_LSB +: 16] = c.start_code;
        d[END_LSB +: 16]   = c.end_code;
        d[DELTA_LSB +: 16] = c.id_delta;
        d[RANGE_LSB +: 16] = c.range_offset;
        d[GID_LSB +: 16]   = c.glyph_id;
        while (src_gaps && $urandom_range(0, 99) < 31) begin
            s_valid = 1'b0;
            @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data  = d;
        s_user  = c.mode;
        do @(posedge i_clk); while (!s_ready);
        results_due.push_back(apply_cmd(c));
        @(negedge i_clk);
    endtask

    task automatic wait_quiet();
        s_valid = 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_segment_count(input logic [14:0] value);
        wait_quiet();
        cfg_wen   = 1'b1;
        cfg_wdata = value;
        @(negedge i_clk);
        cfg_wen   = 1'b0;
        seg_count = value;
    endtask

    // Load any store word in the range that has never been written.
    task automatic ensure_words(input int lo, input int hi);
        int i;
        for (i = (lo < 0) ? 0 : lo; i <= hi && i < STORE_WORDS; i++) begin
            if (!word_loaded[i])
                issue_cmd(load_cmd(12'(i), random_word()));
        end
    endtask

    task automatic send_random_segment();
        t_map_cmd c;
        int       span;
        int       kind;
        int       base;
        int       total;
        int       lo;
        int       hi;
        int       offs;
        t_code    first;
        c    = noise_cmd();
        c.mode = MODE_SEG;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 99)) inside
            [0:79]:  span = $urandom_range(0, 31);
            [80:96]: span = $urandom_range(32, 400);
            default: span = $urandom_range(401, 3000);
        endcase
        // keep indirect segments short so few store words need loading
        if (kind >= 55 && span > 150)
            span = $urandom_range(0, 150);
        c.start_code = t_code'($urandom_range(0, 16'hFFFE - span));
        c.end_code   = c.start_code + t_code'(span);
        if (kind < 8) begin
            case ($urandom_range(0, 2))
                0:       c.start_code = SKIP_CODE;
                1:       c.end_code   = SKIP_CODE;
                default: begin
                    c.start_code = SKIP_CODE;
                    c.end_code   = SKIP_CODE;
                end
            endcase
        end else if (kind < 14) begin
            first        = c.start_code;
            c.start_code = c.end_code + 16'd1;
            c.end_code   = first;
        end else if (kind < 55) begin
            c.range_offset = '0;
        end else begin
            // stay in a low window of the store, or straddle either end of it
            if ($urandom_range(0, 99) < 85)
                base = $urandom_range(0, WORD_WINDOW - 1 - span);
            else
                base = int'($urandom_range(0, 80)) - 40
                     + (($urandom_range(0, 1) != 0) ? STORE_WORDS - span : 0);
            total = base + int'(seg_count);
            if (total < 0) begin
                base  = -int'(seg_count);
                total = 0;
            end
            lo = (total > 32767) ? total - 32767 : 0;
            hi = (total < 32767) ? total : 32767;
            c.segment_number = 15'($urandom_range(lo, hi));
            offs = total - int'(c.segment_number);
            c.range_offset = {offs[14:0], (offs == 0) ? 1'b1 : 1'($urandom_range(0, 1))};
            ensure_words(base, base + span);
        end
        issue_cmd(c);
    endtask

    task automatic test_load_and_lookup();
        issue_cmd(lookup_cmd(16'h0000));
        set_segment_count(15'd1);
        issue_cmd(lookup_cmd(16'hFFFF));
        issue_cmd(load_cmd(12'd0, 16'h0005));
        issue_cmd(load_cmd(12'd1, 16'h0000));
        issue_cmd(load_cmd(12'd2, 16'hFFFF));
        issue_cmd(load_cmd(12'd3, 16'h0005));
        issue_cmd(load_cmd(12'hFFF, 16'h1234));
    endtask

    task automatic test_delta_mapping();
        // code zero lands in the map but reads back as empty
        issue_cmd(segment_cmd(15'd0, 16'h0000, 16'h0003, 16'h0010, 16'h0000));
        // wrap around the top of the map
        issue_cmd(segment_cmd(15'd0, 16'hFFF0, 16'hFFFE, 16'h0020, 16'h0000));
        // a single code whose delta wraps it onto entry 5
        issue_cmd(segment_cmd(15'd0, 16'h0007, 16'h0007, 16'hFFFE, 16'h0000));
        issue_cmd(lookup_cmd(16'h0010));
        issue_cmd(lookup_cmd(16'h001E));
    endtask

    task automatic test_skip_and_reverse();
        issue_cmd(segment_cmd(15'd0, SKIP_CODE, SKIP_CODE, 16'h0001, 16'h0000));
        issue_cmd(segment_cmd(15'd0, 16'h0005, SKIP_CODE, 16'h0001, 16'h0000));
        issue_cmd(segment_cmd(15'd1, SKIP_CODE, 16'h0003, 16'h0001, 16'h0001));
        issue_cmd(segment_cmd(15'd0, 16'h000A, 16'h0005, 16'h0001, 16'h0000));
    endtask

    task automatic test_indirect_mapping();
        // words 5, 0, 0xFFFF, 5: zero word skipped, duplicate target kept
        issue_cmd(segment_cmd(15'd1, 16'd100, 16'd103, 16'h0000, 16'h0001));
        // first code falls below the store
        issue_cmd(segment_cmd(15'd0, 16'd200, 16'd202, 16'h0003, 16'h0001));
        // last code falls past the top of the store
        issue_cmd(segment_cmd(15'd1, 16'd300, 16'd301, 16'h0000, 16'd8190));
        issue_cmd(lookup_cmd(16'h0005));
        issue_cmd(lookup_cmd(16'h1234));
    endtask

    task automatic test_clear();
        issue_cmd(clear_cmd());
        issue_cmd(lookup_cmd(16'h0005));
    endtask

    task automatic test_segment_count_extremes();
        set_segment_count(15'h7FFF);
        issue_cmd(segment_cmd(15'h7FFF, 16'd500, 16'd501, 16'h0000, 16'hFFFE));
        issue_cmd(segment_cmd(15'h7FFF, 16'd600, 16'd602, 16'h0100, 16'h0001));
        issue_cmd(segment_cmd(15'd0, 16'd700, 16'd700, 16'h0000, 16'hFFFF));
        issue_cmd(lookup_cmd(16'h0105));
        // every code but the skip code
        issue_cmd(segment_cmd(15'($urandom), 16'h0000, 16'hFFFE, t_code'($urandom), 16'h0000));
        issue_cmd(lookup_cmd(t_code'($urandom)));
        issue_cmd(clear_cmd());
    endtask

    task automatic test_random_tables();
        int    phase;
        int    k;
        int    clear_at;
        int    roll;
        t_code gid;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       set_segment_count(15'd1);
                1:       set_segment_count(15'h7FFF);
                2:       set_segment_count(15'($urandom_range(2, 32766)));
                default: set_segment_count(15'($urandom_range(1, 64)));
            endcase
            // one phase runs with both sides streaming back to back
            src_gaps = (phase != 2);
            snk_gaps = (phase != 2);
            clear_at = $urandom_range(PHASE_ITEMS / 2, PHASE_ITEMS - 1);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (k == clear_at) begin
                    issue_cmd(clear_cmd());
                end else if (roll < 14) begin
                    issue_cmd(load_cmd(12'($urandom), random_word()));
                end else if (roll < 60) begin
                    send_random_segment();
                end else begin
                    if (hot_glyphs.size() != 0 && $urandom_range(0, 99) < 60)
                        gid = hot_glyphs[$urandom_range(0, hot_glyphs.size() - 1)];
                    else
                        gid = t_code'($urandom);
                    issue_cmd(lookup_cmd(gid));
                end
            end
        end
        src_gaps = 1'b1;
        snk_gaps = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: result with nothing pending, data %h", $time, m_data);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (m_data[CP_LSB +: 16] !== want.code_point) begin
                    $display("%0t: code_point expected %h actual %h", $time,
                             want.code_point, m_data[CP_LSB +: 16]);
                    errors++;
                end
                if (m_data[EW_LSB +: 17] !== want.entries_written) begin
                    $display("%0t: entries_written expected %0d actual %0d", $time,
                             want.entries_written, m_data[EW_LSB +: 17]);
                    errors++;
                end
                if (m_data[BAD_BIT] !== want.bad_offset) begin
                    $display("%0t: bad_offset expected %b actual %b", $time,
                             want.bad_offset, m_data[BAD_BIT]);
                    errors++;
                end
            end
        end
    end

    // Count cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        foreach (rev_map[i]) rev_map[i] = '0;
        seg_count = 15'd1;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_load_and_lookup();
        test_delta_mapping();
        test_skip_and_reverse();
        test_indirect_mapping();
        test_clear();
        test_segment_count_extremes();
        test_random_tables();
        wait_quiet();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/csrm_pkg.sv
rtl/csrm_ram.sv
rtl/cmap_segment_reverse_mapper_top.sv
dv/tb.sv
